// ===== rtl/tempo_map_time_warp_defines.svh =====
// ----------------------------------------------------------------------------
// Tempo map time warp: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef TEMPO_MAP_TIME_WARP_DEFINES_SVH
`define TEMPO_MAP_TIME_WARP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TMTW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TMTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tmtw_pkg.sv =====
// ----------------------------------------------------------------------------
// Tempo map time warp: package
// Operation codes, controller states, control structs and the tempo decoder.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int OUT_W   = 39;
    localparam int START_W = 32;
    localparam int TEMPO_W = 16;
    localparam int CODE_W  = 4;

    // Code of a factor of one; codes below it divide, codes above multiply.
    localparam logic [CODE_W-1:0] CODE_UNITY = 4'd5;

    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_APPEND = 2'd1;
    localparam t_op OP_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_SAT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;  // word taken this cycle
        logic first;   // first map entry is on the read port
        logic step;    // add a whole segment and advance
        logic last;    // add the segment that holds the query time
        logic emit;    // saturate and present the query result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_req; // offered word is a query on a non-empty map
        logic go_on;    // query time lies beyond the next segment start
    } t_sts;

    // Tempo to shift code (k + 5): slow tempos scale up, fast tempos scale down.
    function automatic logic [CODE_W-1:0] tempo_code(input logic [TEMPO_W-1:0] tempo);
        logic [CODE_W-1:0] code;
        code = CODE_UNITY;
        if (tempo < 16'd2)       code = 4'd10;
        else if (tempo < 16'd4)  code = 4'd9;
        else if (tempo < 16'd8)  code = 4'd8;
        else if (tempo < 16'd16) code = 4'd7;
        else if (tempo < 16'd32) code = 4'd6;
        if (tempo > 16'd4080)      code = 4'd0;
        else if (tempo > 16'd2040) code = 4'd1;
        else if (tempo > 16'd1020) code = 4'd2;
        else if (tempo > 16'd510)  code = 4'd3;
        else if (tempo > 16'd255)  code = 4'd4;
        return code;
    endfunction

endpackage

// ===== rtl/tmtw_ram.sv =====
// ----------------------------------------------------------------------------
// Tempo map time warp: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmtw_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/tmtw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tempo map time warp: controller
// Sequences the segment walk of a query; other operations finish on accept.
// ----------------------------------------------------------------------------
module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = start;
                if (start && i_sts.walk_req) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.first = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (i_sts.go_on) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.last = 1'b1;
                    n_state    = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/tmtw_dp.sv =====
// ----------------------------------------------------------------------------
// Tempo map time warp: datapath
// Map storage, entry count, running warp accumulator and result registers.
// ----------------------------------------------------------------------------
module tmtw_dp
    import tmtw_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_op                       i_op,
    input  logic signed [START_W-1:0] i_segment_start,
    input  logic [TEMPO_W-1:0]        i_segment_tempo,
    input  logic signed [START_W-1:0] i_query_time,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic                      o_done,
    output logic signed [OUT_W-1:0]   o_mapped_time,
    output logic                      o_status
);

    localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ACC_W  = 40 + $clog2(MAX_SEGMENTS);
    localparam int SUM_W  = ACC_W + 6;
    localparam int DIFF_W = START_W + 1;
    localparam int ENT_W  = START_W + CODE_W;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_idx;
    logic signed [START_W-1:0] r_qt;
    logic signed [START_W-1:0] r_prev_start;
    logic [CODE_W-1:0]         r_prev_code;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    logic signed [OUT_W-1:0]   r_mapped;
    logic                      r_status;

    logic                      w_full;
    logic                      w_wr_en;
    logic [IDX_W-1:0]          w_rd_addr;
    logic [CNT_W:0]            w_idx_p1;
    logic [CNT_W:0]            w_idx_p2;
    logic [ENT_W-1:0]          w_rd_data;
    logic signed [START_W-1:0] w_rd_start;
    logic [CODE_W-1:0]         w_rd_code;
    logic signed [START_W-1:0] w_end;
    logic signed [DIFF_W-1:0]  w_d;
    logic [2:0]                w_up_sh;
    logic [2:0]                w_dn_sh;
    logic signed [ACC_W-1:0]   w_d_acc;
    logic signed [ACC_W-1:0]   w_up;
    logic signed [SUM_W-1:0]   w_acc_s;
    logic signed [SUM_W-1:0]   w_d_s;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_flo;
    logic [SUM_W-1:0]          w_mask;
    logic                      w_rnd;
    logic [SUM_W-1:0]          w_dn;
    logic signed [ACC_W-1:0]   w_next;
    logic signed [OUT_W-1:0]   w_sat;
    logic                      w_emit_now;

    assign w_full  = (r_count == CNT_W'(MAX_SEGMENTS));
    assign w_wr_en = i_cmd.accept && (i_op == OP_APPEND) && !w_full;

    assign w_idx_p1 = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign w_idx_p2 = {1'b0, r_idx} + (CNT_W+1)'(2);

    // The walk keeps one entry ahead on the read port: the next start
    // decides whether the current segment is passed whole.
    always_comb begin
        if (i_cmd.accept) begin
            w_rd_addr = '0;
        end else if (i_cmd.first) begin
            w_rd_addr = IDX_W'(1);
        end else begin
            w_rd_addr = w_idx_p2[IDX_W-1:0];
        end
    end

    tmtw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({i_segment_start, tempo_code(i_segment_tempo)}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_start = w_rd_data[ENT_W-1:CODE_W];
    assign w_rd_code  = w_rd_data[CODE_W-1:0];

    assign o_sts.walk_req = (i_op == OP_QUERY) && (r_count != '0);
    assign o_sts.go_on    = (w_idx_p1 < {1'b0, r_count}) && (r_qt > w_rd_start);

    // Segment length: to the next start, or to the query time on the last one.
    assign w_end = i_cmd.last ? r_qt : w_rd_start;
    assign w_d   = {w_end[START_W-1], w_end} - {r_prev_start[START_W-1], r_prev_start};

    assign w_up_sh = 3'(r_prev_code - CODE_UNITY);
    assign w_dn_sh = 3'(CODE_UNITY - r_prev_code);

    assign w_d_acc = {{(ACC_W-DIFF_W){w_d[DIFF_W-1]}}, w_d};
    assign w_up    = r_acc + (w_d_acc <<< w_up_sh);

    // Fractional factor: scale the sum up, add, then divide back with
    // truncation toward zero (floor shift, plus one for inexact negatives).
    assign w_acc_s = {{(SUM_W-ACC_W){r_acc[ACC_W-1]}}, r_acc};
    assign w_d_s   = {{(SUM_W-DIFF_W){w_d[DIFF_W-1]}}, w_d};
    assign w_sum   = (w_acc_s <<< w_dn_sh) + w_d_s;
    assign w_flo   = w_sum >>> w_dn_sh;
    assign w_mask  = (SUM_W'(1) << w_dn_sh) - SUM_W'(1);
    assign w_rnd   = w_sum[SUM_W-1] && ((w_sum & w_mask) != '0);
    assign w_dn    = w_flo + SUM_W'(w_rnd);

    assign w_next = (r_prev_code >= CODE_UNITY) ? w_up : w_dn[ACC_W-1:0];

    always_comb begin
        if (r_acc > SAT_HI) begin
            w_sat = SAT_HI[OUT_W-1:0];
        end else if (r_acc < SAT_LO) begin
            w_sat = SAT_LO[OUT_W-1:0];
        end else begin
            w_sat = r_acc[OUT_W-1:0];
        end
    end

    assign w_emit_now = i_cmd.accept && !o_sts.walk_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_emit_now || i_cmd.emit;
            if (i_cmd.accept && (i_op == OP_CLEAR)) begin
                r_count <= '0;
            end else if (w_wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_qt <= i_query_time;
        end
        if (i_cmd.first) begin
            r_idx        <= '0;
            r_acc        <= '0;
            r_prev_start <= w_rd_start;
            r_prev_code  <= w_rd_code;
        end else if (i_cmd.step) begin
            r_idx        <= w_idx_p1[CNT_W-1:0];
            r_acc        <= w_next;
            r_prev_start <= w_rd_start;
            r_prev_code  <= w_rd_code;
        end else if (i_cmd.last) begin
            r_acc <= w_next;
        end
        if (w_emit_now) begin
            r_status <= (i_op == OP_APPEND) && w_full;
            if (i_op == OP_QUERY) begin
                r_mapped <= {{(OUT_W-START_W){i_query_time[START_W-1]}}, i_query_time};
            end else begin
                r_mapped <= '0;
            end
        end else if (i_cmd.emit) begin
            r_status <= 1'b0;
            r_mapped <= w_sat;
        end
    end

    assign o_done        = r_done;
    assign o_mapped_time = r_mapped;
    assign o_status      = r_status;

endmodule

// ===== rtl/tempo_map_time_warp.sv =====
// ----------------------------------------------------------------------------
// Tempo map time warp
// Tempo map of up to MAX_SEGMENTS segments with clear, append and query.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Clear, append and a
// query on an empty map raise o_done in the next cycle. A query on a non-empty
// map walks the stored segments one per clock through the single read port of
// the map memory: busy is high in S_FETCH, S_WALK and S_SAT, and S_WALK passes
// w whole segments (at most MAX_SEGMENTS - 1), then the last one. o_done rises
// in the same cycle as busy falls. Each result is shown for exactly one cycle
// and cannot be held off, so the receiver must take it then.
// ----------------------------------------------------------------------------
`include "tempo_map_time_warp_defines.svh"

module tempo_map_time_warp
    import tmtw_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_op,
    input  logic signed [START_W-1:0] i_segment_start,
    input  logic [TEMPO_W-1:0]        i_segment_tempo,
    input  logic signed [START_W-1:0] i_query_time,
    output logic                      o_done,
    output logic signed [OUT_W-1:0]   o_mapped_time,
    output logic                      o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    tmtw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tmtw_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_op),
        .i_segment_start (i_segment_start),
        .i_segment_tempo (i_segment_tempo),
        .i_query_time    (i_query_time),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_done          (o_done),
        .o_mapped_time   (o_mapped_time),
        .o_status        (o_status)
    );

    // A word that needs no walk is answered in the very next cycle.
    `TMTW_ASSERT_NEXT(a_quick_done, w_cmd.accept && !w_sts.walk_req, o_done, "quick op lost")

    // A finished walk presents its result and frees the block together.
    `TMTW_ASSERT_NEXT(a_walk_done, w_cmd.emit, o_done && !busy, "walk result lost")

    // A dropped append never carries a warped time.
    `TMTW_ASSERT_NOW(a_drop_zero, o_done && o_status, o_mapped_time == '0, "bad drop word")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Tempo map time warp: testbench
// Loads tempo maps through clear and append words, warps query times through
// them and checks every result word against a local model of the map or a
// fixed value. A short table of hand-picked words comes first. Random maps
// follow: sorted, unsorted, zigzag maps that saturate the result, plus noise.
// ----------------------------------------------------------------------------
module tb_top;
    import tmtw_pkg::*;

    localparam int MAP_DEPTH = 16;
    localparam int WORD_TARGET = 1050;
    localparam int CALM_FROM = 900;
    localparam int DRAIN_CYCLES = 40;

    localparam t_op OP_UNUSED = 2'd3;

    localparam int START_MIN = 32'sh8000_0000;
    localparam int START_MAX = 32'sh7FFF_FFFF;
    localparam longint T_MIN = -64'sd2147483648;
    localparam longint T_MAX = 64'sd2147483647;
    localparam longint WARP_MAX = 64'sd274877906943;
    localparam longint WARP_MIN = -WARP_MAX - 64'sd1;

    localparam logic [15:0] TEMPO_EDGES [22] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd7, 16'd8, 16'd15, 16'd16, 16'd31,
        16'd32, 16'd255, 16'd256, 16'd510, 16'd511, 16'd1020, 16'd1021,
        16'd2040, 16'd2041, 16'd4080, 16'd4081, 16'd65535
    };

    typedef struct packed {
        t_op         op;
        int          seg_start;
        logic [15:0] seg_tempo;
        int          q_time;
        bit          has_fixed;
        longint      fixed_time;
        bit          fixed_status;
    } t_row;

    typedef struct packed {
        logic [OUT_W-1:0] mapped;
        logic             status;
    } t_result;

    // Hand-picked words; a fixed expectation is given only where it is obvious.
    t_row directed_plan [25] = '{
        '{OP_QUERY,  0,           16'd0,     START_MIN, 1'b1, T_MIN,  1'b0},
        '{OP_QUERY,  0,           16'd0,     START_MAX, 1'b1, T_MAX,  1'b0},
        '{OP_UNUSED, -1,          16'hFFFF,  -1,        1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, START_MIN,   16'd0,     0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, -1000000,    16'd3,     0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, -5000,       16'd4,     0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, -100,        16'd15,    0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 0,           16'd16,    0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 0,           16'd31,    0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 7,           16'd32,    0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 500,         16'd255,   0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 1000,        16'd256,   0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 2000,        16'd510,   0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 3000,        16'd511,   0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 40000,       16'd1020,  0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 50000,       16'd1021,  0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 1000000,     16'd2040,  0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 2000000,     16'd4081,  0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, START_MAX,   16'd65535, 0,         1'b1, 64'sd0, 1'b0},
        '{OP_APPEND, 123,         16'd1,     0,         1'b1, 64'sd0, 1'b1},
        '{OP_QUERY,  0,           16'd0,     START_MAX, 1'b0, 64'sd0, 1'b0},
        '{OP_QUERY,  0,           16'd0,     START_MIN, 1'b0, 64'sd0, 1'b0},
        '{OP_QUERY,  0,           16'd0,     2500,      1'b0, 64'sd0, 1'b0},
        '{OP_CLEAR,  0,           16'd0,     0,         1'b1, 64'sd0, 1'b0},
        '{OP_QUERY,  0,           16'd0,     -12345,    1'b1, -64'sd12345, 1'b0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    t_op                       i_op;
    logic signed [START_W-1:0] i_segment_start;
    logic [TEMPO_W-1:0]        i_segment_tempo;
    logic signed [START_W-1:0] i_query_time;
    logic                      o_done;
    logic signed [OUT_W-1:0]   o_mapped_time;
    logic                      o_status;

    // Local copy of the tempo map.
    int          map_start [MAP_DEPTH];
    logic [3:0]  map_code [MAP_DEPTH];
    int          map_count;

    t_result awaited_results[$];
    int      mismatch_count;
    int      words_sent;
    bit      gaps_on;

    tempo_map_time_warp #(
        .MAX_SEGMENTS(MAP_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_segment_start(i_segment_start),
        .i_segment_tempo(i_segment_tempo),
        .i_query_time   (i_query_time),
        .o_done         (o_done),
        .o_mapped_time  (o_mapped_time),
        .o_status       (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Shift code is k + 5 for a factor of 2^k.
    function automatic logic [3:0] tempo_to_code(input logic [15:0] tempo);
        int k;
        k = 0;
        if (tempo < 2) k = 5;
        else if (tempo < 4) k = 4;
        else if (tempo < 8) k = 3;
        else if (tempo < 16) k = 2;
        else if (tempo < 32) k = 1;
        if (tempo > 4080) k = -5;
        else if (tempo > 2040) k = -4;
        else if (tempo > 1020) k = -3;
        else if (tempo > 510) k = -2;
        else if (tempo > 255) k = -1;
        return 4'(k + 5);
    endfunction

    // acc + len * 2^k, truncated toward zero when k is negative.
    function automatic longint scaled_add(input longint acc, input longint len,
                                          input logic [3:0] code);
        int     k;
        longint den;
        k = int'(code) - 5;
        if (k >= 0) return acc + len * (longint'(1) << k);
        den = longint'(1) << (-k);
        return (acc * den + len) / den;
    endfunction

    function automatic logic signed [OUT_W-1:0] warp_time(input int t);
        longint acc;
        int     idx;
        acc = 0;
        idx = 0;
        if (map_count == 0) return OUT_W'(t);
        while (idx + 1 < map_count && t > map_start[idx + 1]) begin
            acc = scaled_add(acc, longint'(map_start[idx + 1]) - longint'(map_start[idx]),
                             map_code[idx]);
            idx++;
        end
        acc = scaled_add(acc, longint'(t) - longint'(map_start[idx]), map_code[idx]);
        if (acc > WARP_MAX) acc = WARP_MAX;
        if (acc < WARP_MIN) acc = WARP_MIN;
        return acc[OUT_W-1:0];
    endfunction

    task automatic predict_word(input t_op op, input int seg_start, input logic [15:0] tempo,
                                input int q_time, output t_result res);
        res.mapped = '0;
        res.status = 1'b0;
        case (op)
            OP_CLEAR: map_count = 0;
            OP_APPEND: begin
                if (map_count < MAP_DEPTH) begin
                    map_start[map_count] = seg_start;
                    map_code[map_count] = tempo_to_code(tempo);
                    map_count++;
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_QUERY: res.mapped = warp_time(q_time);
            default: ;
        endcase
    endtask

    // Offers one word, waits for it to be taken and records its expected result.
    task automatic send_word(input t_op op, input int seg_start, input logic [15:0] tempo,
                             input int q_time, input bit has_fixed, input longint fixed_time,
                             input bit fixed_status);
        t_result res;
        int      gap;
        @(negedge i_clk);
        start <= 1'b1;
        i_op <= op;
        i_segment_start <= seg_start;
        i_segment_tempo <= tempo;
        i_query_time <= q_time;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_word(op, seg_start, tempo, q_time, res);
        if (has_fixed) begin
            res.mapped = fixed_time[OUT_W-1:0];
            res.status = fixed_status;
        end
        awaited_results.insert(awaited_results.size(), res);
        words_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic clear_map();
        send_word(OP_CLEAR, $urandom, 16'($urandom), $urandom, 1'b0, 0, 1'b0);
    endtask

    task automatic add_segment(input int seg_start, input logic [15:0] tempo);
        send_word(OP_APPEND, seg_start, tempo, $urandom, 1'b0, 0, 1'b0);
    endtask

    task automatic ask_time(input int t);
        send_word(OP_QUERY, $urandom, 16'($urandom), t, 1'b0, 0, 1'b0);
    endtask

    function automatic int clamp_start(input longint v);
        if (v > longint'(START_MAX)) return START_MAX;
        if (v < longint'(START_MIN)) return START_MIN;
        return int'(v);
    endfunction

    function automatic int pick_in_window(input longint lo, input longint span);
        longint offs;
        offs = longint'({$urandom, $urandom} % 64'(span + 1));
        return clamp_start(lo + offs);
    endfunction

    function automatic logic [15:0] pick_tempo();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return TEMPO_EDGES[$urandom_range(0, 21)];
        if (sel < 8) return 16'($urandom_range(0, 300));
        return 16'($urandom);
    endfunction

    // Every strobed word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_done !== 1'b0) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result word with none expected, got mapped_time %0d status %0b",
                         $time, o_mapped_time, o_status);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_mapped_time !== want.mapped) begin
                    $display("%0t: mapped_time mismatch, expected %0d, got %0d",
                             $time, $signed(want.mapped), o_mapped_time);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0b, got %0b",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int     kind;
        int     n;
        int     p;
        longint lo;
        longint span;
        longint t;
        int     starts[$];
        t_op    op;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = OP_CLEAR;
        i_segment_start = '0;
        i_segment_tempo = '0;
        i_query_time = '0;
        map_count = 0;
        mismatch_count = 0;
        words_sent = 0;
        gaps_on = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < 25; r++) begin
            send_word(directed_plan[r].op, directed_plan[r].seg_start,
                      directed_plan[r].seg_tempo, directed_plan[r].q_time,
                      directed_plan[r].has_fixed, directed_plan[r].fixed_time,
                      directed_plan[r].fixed_status);
        end

        while (words_sent < WORD_TARGET) begin
            gaps_on = (words_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                // Map drawn from a window; most maps are sorted, some are not.
                clear_map();
                case ($urandom_range(0, 2))
                    0: begin lo = -5000; span = 10000; end
                    1: begin lo = longint'(int'($urandom)); span = $urandom_range(1, 1 << 20); end
                    default: begin lo = T_MIN; span = 64'd4294967295; end
                endcase
                n = ($urandom_range(0, 3) == 0) ? MAP_DEPTH : $urandom_range(1, MAP_DEPTH);
                starts.delete();
                repeat (n) starts.insert(starts.size(), pick_in_window(lo, span));
                if (kind < 60) starts.sort();
                foreach (starts[i]) add_segment(starts[i], pick_tempo());
                if (n == MAP_DEPTH && $urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 3)) add_segment($urandom, 16'($urandom));
                end
                repeat ($urandom_range(2, 10)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: t = longint'(starts[$urandom_range(0, n - 1)])
                                        + $urandom_range(0, 6) - 3;
                        4, 5, 6: t = pick_in_window(lo - span / 4, span + span / 2);
                        7, 8: t = longint'(int'($urandom));
                        default: t = $urandom_range(0, 1) ? T_MAX : T_MIN;
                    endcase
                    if ($urandom_range(0, 19) == 0) begin
                        send_word(OP_UNUSED, $urandom, 16'($urandom), $urandom, 1'b0, 0, 1'b0);
                    end
                    ask_time(clamp_start(t));
                end
            end else if (kind < 85) begin
                // Starts jump between the extremes, with a slow tempo on the way
                // in one direction and a fast one on the way back, so that the
                // result runs into the saturation limit.
                clear_map();
                p = $urandom_range(0, 1);
                n = $urandom_range(8, MAP_DEPTH);
                for (int i = 0; i < n; i++) begin
                    add_segment(((i % 2 == 0) == (p == 1)) ? START_MIN : START_MAX - 1,
                                (i % 2 == 0) ? 16'd0 : 16'hFFFF);
                end
                ask_time(START_MAX);
                ask_time(START_MAX - 1);
                ask_time($urandom);
            end else if (kind < 95) begin
                repeat ($urandom_range(10, 30)) begin
                    op = t_op'($urandom_range(0, 3));
                    if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_QUERY;
                    send_word(op, $urandom, 16'($urandom), $urandom, 1'b0, 0, 1'b0);
                end
            end else begin
                clear_map();
                repeat ($urandom_range(2, 6)) ask_time($urandom);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== tempo_map_time_warp.f =====
+incdir+rtl
rtl/tmtw_pkg.sv
rtl/tmtw_ram.sv
rtl/tmtw_ctrl.sv
rtl/tmtw_dp.sv
rtl/tempo_map_time_warp.sv
dv/tb_top.sv
